### rtl/skvi_pkg.sv
// ----------------------------------------------------------------------------
// skvi_pkg
// Shared types and constants for the sorted key/value insert block: the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package skvi_pkg;

  localparam int KEY_IN_WIDTH = 32;
  localparam int VALUE_WIDTH  = 32;

  typedef struct packed {
    logic load;
    logic search_rd;
    logic probe_eval;
    logic shift_begin;
    logic shift_step;
    logic insert;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic lo_lt_hi;
    logic full;
    logic need_shift;
    logic more_shift;
    logic out_free;
  } status_t;

endpackage

### rtl/skvi_ram.sv
// ----------------------------------------------------------------------------
// skvi_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module skvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/skvi_datapath.sv
// ----------------------------------------------------------------------------
// skvi_datapath
// Search bounds, shift pointer, entry count, key and value stores and the
// result register of the sorted key/value insert block.
// ----------------------------------------------------------------------------
module skvi_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  skvi_pkg::cmd_t                       cmd,
  output skvi_pkg::status_t                    status,
  input  logic [skvi_pkg::KEY_IN_WIDTH-1:0]    lookup_key,
  input  logic [skvi_pkg::VALUE_WIDTH-1:0]     new_value,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [$clog2(TABLE_DEPTH)-1:0]       slot_index,
  output logic [skvi_pkg::VALUE_WIDTH-1:0]     stored_value,
  output logic                                 was_present,
  output logic                                 table_full,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VW = skvi_pkg::VALUE_WIDTH;
  localparam int IW = skvi_pkg::KEY_IN_WIDTH;

  logic [IW+KEY_WIDTH-1:0] key_ext;
  logic [KEY_WIDTH-1:0]    key_in;
  logic [KEY_WIDTH-1:0]    search_key;
  logic [VW-1:0]           insert_value;
  logic [VW-1:0]           found_value;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic [AW-1:0]           wp;
  logic [CW-1:0]           used_entries;
  logic                    found;
  logic                    inserted;
  logic [CW:0]             bound_sum;
  logic [CW:0]             mid_full;
  logic [AW-1:0]           mid;
  logic [CW-1:0]           count_dec;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  logic [KEY_WIDTH-1:0]    key_wdata;
  logic [VW-1:0]           val_wdata;
  logic [KEY_WIDTH-1:0]    key_rdata;
  logic [VW-1:0]           val_rdata;

  assign key_ext   = {{KEY_WIDTH{1'b0}}, lookup_key};
  assign key_in    = key_ext[KEY_WIDTH-1:0];
  assign bound_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_full  = bound_sum >> 1;
  assign mid       = mid_full[AW-1:0];
  assign count_dec = used_entries - CW'(1);

  always_comb begin
    rd_addr = '0;
    if (cmd.search_rd) begin
      rd_addr = mid;
    end else if (cmd.shift_begin) begin
      rd_addr = count_dec[AW-1:0];
    end else if (cmd.shift_step) begin
      rd_addr = wp - AW'(2);
    end
  end

  assign wr_en     = cmd.shift_step | cmd.insert;
  assign wr_addr   = cmd.insert ? lo[AW-1:0] : wp;
  assign key_wdata = cmd.insert ? search_key : key_rdata;
  assign val_wdata = cmd.insert ? insert_value : val_rdata;

  skvi_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key_wdata),
    .rd_addr (rd_addr),
    .rd_data (key_rdata)
  );

  skvi_ram #(
    .WIDTH (VW),
    .DEPTH (TABLE_DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_wdata),
    .rd_addr (rd_addr),
    .rd_data (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      search_key   <= key_in;
      insert_value <= new_value;
      hi           <= used_entries;
    end
    if (cmd.probe_eval && key_rdata != search_key && search_key < key_rdata) begin
      hi <= CW'(mid);
    end
    if (cmd.probe_eval && key_rdata == search_key) begin
      found_value <= val_rdata;
    end
    if (cmd.shift_begin) begin
      wp <= used_entries[AW-1:0];
    end else if (cmd.shift_step) begin
      wp <= wp - AW'(1);
    end
    if (cmd.load) begin
      lo <= '0;
    end else if (cmd.probe_eval) begin
      if (key_rdata == search_key) begin
        lo <= CW'(mid);
      end else if (search_key > key_rdata) begin
        lo <= CW'(mid) + CW'(1);
      end
    end
    if (cmd.result_load) begin
      slot_index   <= (found || inserted) ? lo[AW-1:0] : '0;
      stored_value <= found ? found_value : (inserted ? insert_value : '0);
      was_present  <= found;
      table_full   <= !found && !inserted;
      entry_count  <= used_entries;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_entries <= '0;
      found        <= 1'b0;
      inserted     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        found    <= 1'b0;
        inserted <= 1'b0;
      end else begin
        if (cmd.probe_eval && key_rdata == search_key) begin
          found <= 1'b1;
        end
        if (cmd.insert) begin
          inserted     <= 1'b1;
          used_entries <= used_entries + CW'(1);
        end
      end
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.found      = found;
  assign status.lo_lt_hi   = lo < hi;
  assign status.full       = used_entries == CW'(TABLE_DEPTH);
  assign status.need_shift = used_entries > lo;
  assign status.more_shift = CW'(wp) > (lo + CW'(1));
  assign status.out_free   = !out_valid || !out_stall;

endmodule

### rtl/skvi_ctrl.sv
// ----------------------------------------------------------------------------
// skvi_ctrl
// Controller of the sorted key/value insert block: sequences the binary
// search, the shift of upper entries, the insert and the result load.
// ----------------------------------------------------------------------------
module skvi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  skvi_pkg::status_t status,
  output skvi_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_PROBE  = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_INSERT = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.found) begin
          state_next = ST_FINISH;
        end else if (status.lo_lt_hi) begin
          cmd.search_rd = 1'b1;
          state_next    = ST_PROBE;
        end else if (status.full) begin
          state_next = ST_FINISH;
        end else if (status.need_shift) begin
          cmd.shift_begin = 1'b1;
          state_next      = ST_SHIFT;
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_PROBE: begin
        cmd.probe_eval = 1'b1;
        state_next     = ST_SEARCH;
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (!status.more_shift) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/sorted_key_value_insert.sv
// ----------------------------------------------------------------------------
// sorted_key_value_insert
// Sorted key/value table: binary search for a key, return its slot and value,
// or shift the upper entries up one slot and insert the new pair if not full.
//
//   channel  handshake          payload
//   input    in_valid/in_stall  lookup_key, new_value
//   output   out_valid/out_stall slot_index, stored_value, was_present,
//                               table_full, entry_count
//
// One transaction at a time, with n entries in use: the accept, up to
// ceil(log2(n+1)) search probes, then on a miss the shift of the entries at
// the resulting slot and above and the insert, then the result load. The
// shift moves one entry a cycle through the read and write ports of the key
// and value memories. Reset clears only the entry count and the found,
// inserted and out_valid flags; no clearing pass is needed. A stalled
// result sits in the output register while the next transaction is taken
// and worked on; only its result load waits.
// ----------------------------------------------------------------------------
module sorted_key_value_insert #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [skvi_pkg::KEY_IN_WIDTH-1:0]    lookup_key,
  input  logic [skvi_pkg::VALUE_WIDTH-1:0]     new_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(TABLE_DEPTH)-1:0]       slot_index,
  output logic [skvi_pkg::VALUE_WIDTH-1:0]     stored_value,
  output logic                                 was_present,
  output logic                                 table_full,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     entry_count
);

  skvi_pkg::cmd_t    cmd;
  skvi_pkg::status_t status;

  skvi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  skvi_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .lookup_key   (lookup_key),
    .new_value    (new_value),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .slot_index   (slot_index),
    .stored_value (stored_value),
    .was_present  (was_present),
    .table_full   (table_full),
    .entry_count  (entry_count)
  );

endmodule

### dv/sorted_key_value_insert_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_value_insert_checker
// Passive checker for the sorted key/value table. It keeps its own sorted copy
// of the table, predicts the result of every accepted input transaction, and
// compares each accepted result transaction field by field, in order.
// ----------------------------------------------------------------------------
module sorted_key_value_insert_checker #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 32,
  parameter int SLOT_W      = $clog2(TABLE_DEPTH),
  parameter int COUNT_W     = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [skvi_pkg::KEY_IN_WIDTH-1:0]    lookup_key,
  input  logic [skvi_pkg::VALUE_WIDTH-1:0]     new_value,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [SLOT_W-1:0]                    slot_index,
  input  logic [skvi_pkg::VALUE_WIDTH-1:0]     stored_value,
  input  logic                                 was_present,
  input  logic                                 table_full,
  input  logic [COUNT_W-1:0]                   entry_count,
  output int                                   errors,
  output int                                   pending_results
);

  localparam logic [63:0] KEY_MASK = (64'd1 << KEY_WIDTH) - 64'd1;

  typedef struct packed {
    logic [SLOT_W-1:0]                slot;
    logic [skvi_pkg::VALUE_WIDTH-1:0] value;
    logic                             present;
    logic                             full;
    logic [COUNT_W-1:0]               count;
  } lookup_result_t;

  logic [skvi_pkg::KEY_IN_WIDTH-1:0] key_tbl [TABLE_DEPTH];
  logic [skvi_pkg::VALUE_WIDTH-1:0]  val_tbl [TABLE_DEPTH];
  int                                entries = 0;
  int                                err_count = 0;
  lookup_result_t                    lookup_results_q [$];

  function automatic lookup_result_t predict_lookup(
    input logic [skvi_pkg::KEY_IN_WIDTH-1:0] raw_key,
    input logic [skvi_pkg::VALUE_WIDTH-1:0]  val
  );
    lookup_result_t                    r;
    logic [skvi_pkg::KEY_IN_WIDTH-1:0] k;
    int                                lo;
    int                                hi;
    int                                mid;
    int                                i;
    bit                                hit;
    k   = raw_key & KEY_MASK[skvi_pkg::KEY_IN_WIDTH-1:0];
    r   = '0;
    lo  = 0;
    hi  = entries;
    hit = 1'b0;
    while (lo < hi && !hit) begin
      mid = (lo + hi) >> 1;
      if (key_tbl[mid] == k) begin
        hit = 1'b1;
        lo  = mid;
      end else if (k > key_tbl[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (hit) begin
      r.slot    = SLOT_W'(lo);
      r.value   = val_tbl[lo];
      r.present = 1'b1;
    end else if (entries >= TABLE_DEPTH) begin
      r.full = 1'b1;
    end else begin
      for (i = entries; i > lo; i--) begin
        key_tbl[i] = key_tbl[i-1];
        val_tbl[i] = val_tbl[i-1];
      end
      key_tbl[lo] = k;
      val_tbl[lo] = val;
      entries++;
      r.slot  = SLOT_W'(lo);
      r.value = val;
    end
    r.count = COUNT_W'(entries);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    lookup_result_t want;
    if (rst) begin
      entries = 0;
      lookup_results_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        lookup_results_q.push_back(predict_lookup(lookup_key, new_value));
      end
      if (out_valid && !out_stall) begin
        if (lookup_results_q.size() == 0) begin
          $display("%0t: result transaction with none expected", $time);
          err_count++;
        end else begin
          want = lookup_results_q.pop_front();
          check_field("slot_index", 32'(want.slot), 32'(slot_index));
          check_field("stored_value", want.value, stored_value);
          check_field("was_present", 32'(want.present), 32'(was_present));
          check_field("table_full", 32'(want.full), 32'(table_full));
          check_field("entry_count", 32'(want.count), 32'(entry_count));
        end
      end
    end
    errors          <= err_count;
    pending_results <= lookup_results_q.size();
  end

endmodule

### dv/sorted_key_value_insert_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_value_insert_tb
// Drives lookup/insert transactions into the sorted key/value table: a short
// directed set at the key and value extremes, then random transactions that
// fill the table gradually, mix hits with new keys, and keep hitting it once
// full. Both channels idle and stall at random; the checker gives the verdict.
// ----------------------------------------------------------------------------
module sorted_key_value_insert_tb;

  localparam int TABLE_DEPTH  = 64;
  localparam int KEY_WIDTH    = 32;
  localparam int SLOT_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int RANDOM_ITEMS = 890;
  localparam int CYCLE_LIMIT  = 500000;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [skvi_pkg::KEY_IN_WIDTH-1:0]    lookup_key = '0;
  logic [skvi_pkg::VALUE_WIDTH-1:0]     new_value = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [SLOT_W-1:0]                    slot_index;
  logic [skvi_pkg::VALUE_WIDTH-1:0]     stored_value;
  logic                                 was_present;
  logic                                 table_full;
  logic [COUNT_W-1:0]                   entry_count;
  int                                   errors;
  int                                   pending_results;
  int                                   cycle_count = 0;
  int                                   idle_max = 13;

  logic [31:0] known_keys [$];
  bit          key_seen [logic [31:0]];

  sorted_key_value_insert #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .lookup_key   (lookup_key),
    .new_value    (new_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_index   (slot_index),
    .stored_value (stored_value),
    .was_present  (was_present),
    .table_full   (table_full),
    .entry_count  (entry_count)
  );

  sorted_key_value_insert_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .lookup_key      (lookup_key),
    .new_value       (new_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slot_index      (slot_index),
    .stored_value    (stored_value),
    .was_present     (was_present),
    .table_full      (table_full),
    .entry_count     (entry_count),
    .errors          (errors),
    .pending_results (pending_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : result_drain
    int hold;
    bit took;
    @(posedge clk);
    forever begin
      hold = $urandom_range(0, idle_max);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      took = 1'b0;
      while (!took) begin
        @(negedge clk);
        took = (out_valid === 1'b1);
        @(posedge clk);
      end
    end
  end

  task automatic send_lookup(input logic [31:0] k, input logic [31:0] v);
    int gap;
    bit took;
    if (!key_seen.exists(k) && known_keys.size() < TABLE_DEPTH) begin
      key_seen[k] = 1'b1;
      known_keys.push_back(k);
    end
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    lookup_key <= k;
    new_value  <= v;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = (in_stall === 1'b0);
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  function automatic logic [31:0] fresh_key();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 15));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      2: begin
        if (known_keys.size() == 0) return $urandom();
        if ($urandom_range(0, 1) == 0)
          return known_keys[$urandom_range(0, known_keys.size() - 1)] + 32'd1;
        return known_keys[$urandom_range(0, known_keys.size() - 1)] - 32'd1;
      end
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    int          n;
    int          new_pct;
    logic [31:0] k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_lookup(32'h8000_0000, 32'h1234_5678);
    send_lookup(32'h0000_0000, 32'h0000_0000);
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'h0000_0000, 32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFF, 32'h0000_0000);
    send_lookup(32'h8000_0000, 32'h0BAD_F00D);
    send_lookup(32'h7FFF_FFFF, 32'hAAAA_AAAA);
    send_lookup(32'h8000_0001, 32'h5555_5555);
    send_lookup(32'h0000_0001, 32'h0000_0001);
    send_lookup(32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_lookup(32'h7FFF_FFFF, 32'h0000_0000);
    send_lookup(32'h8000_0001, 32'hFFFF_FFFF);
    wait_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ((n / 64) % 3)
          0: idle_max = 0;
          1: idle_max = 13;
          default: idle_max = 4;
        endcase
      end
      if (n == 300 || n == 600) wait_drained();
      new_pct = (known_keys.size() < TABLE_DEPTH) ? 25 : 50;
      if (known_keys.size() == 0 || $urandom_range(0, 99) < new_pct)
        k = fresh_key();
      else
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      send_lookup(k, $urandom());
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
